[sv/tile_window_diff_pager_defines.svh]
// Assertion macros for the tile window pager RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TILE_WINDOW_DIFF_PAGER_DEFINES_SVH
`define TILE_WINDOW_DIFF_PAGER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TWDP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWDP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TWDP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWDP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[sv/twdp_pkg.sv]
// Types and constants of the tile window pager.
// No dependencies; used by every module of the block.
package twdp_pkg;

  localparam int unsigned SIDE_W  = 3;
  localparam int unsigned COORD_W = 32;

  localparam logic [SIDE_W-1:0] SIDE_RESET  = 3'd3;
  localparam logic              ACT_LOAD    = 1'b0;
  localparam logic              ACT_DISPOSE = 1'b1;

  typedef struct packed {
    logic [29:0] center_tile_x;
    logic [29:0] center_tile_y;
    logic [4:0]  zoom_level;
  } in_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] tile_x;
    logic signed [31:0] tile_y;
    logic [4:0]         tile_zoom;
    logic               last_of_run;
  } out_t;

  // One window update handed from the front to the back.
  typedef struct packed {
    logic signed [COORD_W-1:0] new_x0;
    logic signed [COORD_W-1:0] new_y0;
    logic signed [COORD_W-1:0] old_x0;
    logic signed [COORD_W-1:0] old_y0;
    logic signed [COORD_W-1:0] ld_dx;
    logic signed [COORD_W-1:0] ld_dy;
    logic signed [COORD_W-1:0] ds_dx;
    logic signed [COORD_W-1:0] ds_dy;
    logic [SIDE_W-1:0]         new_side;
    logic [SIDE_W-1:0]         old_side;
    logic [4:0]                new_zoom;
    logic [4:0]                old_zoom;
    logic                      same_zoom;
  } job_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOAD,
    PH_DISPOSE,
    PH_FLUSH
  } phase_e;

endpackage

[sv/tile_window_diff_pager.sv]
// The window scanner checks one tile candidate per cycle while the output does not stall it;
// an unchanged center makes no job for the scanner.
// Reset clears the stored window, the queue and the side register (to 3).
// The scanner walks the new window, then the old one, from a 2-entry job queue.
module tile_window_diff_pager #(
  parameter int unsigned MAX_SIDE = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [twdp_pkg::SIDE_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  twdp_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output twdp_pkg::out_t              out_data_o
);

  logic           push_valid;
  logic           push_ready;
  twdp_pkg::job_t push_job;
  logic           head_valid;
  logic           head_pop;
  twdp_pkg::job_t head_job;

  twdp_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  twdp_job_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_data_o   (head_job)
  );

  twdp_back #(
    .MAX_SIDE(MAX_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (head_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/twdp_front.sv]
// Front end: takes center updates, drops unchanged ones and builds window jobs.
// Depends on twdp_pkg; holds the side register and the stored center.
module twdp_front #(
  parameter int unsigned MAX_SIDE = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [twdp_pkg::SIDE_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  twdp_pkg::in_t                       in_data_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output twdp_pkg::job_t                      job_o
);

  logic [twdp_pkg::SIDE_W-1:0] side_cfg_q;
  logic [29:0]                 used_x_q;
  logic [29:0]                 used_y_q;
  logic [4:0]                  used_zoom_q;
  logic [twdp_pkg::SIDE_W-1:0] used_side_q;
  logic                        win_valid_q;

  logic [twdp_pkg::SIDE_W-1:0] new_side;
  logic [twdp_pkg::SIDE_W-1:0] old_side;
  logic                        changed;
  logic                        accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  assign new_side = (side_cfg_q > twdp_pkg::SIDE_W'(MAX_SIDE)) ?
                    twdp_pkg::SIDE_W'(MAX_SIDE) : side_cfg_q;
  assign old_side = win_valid_q ? used_side_q : '0;

  assign changed = !win_valid_q ||
                   (in_data_i.center_tile_x != used_x_q) ||
                   (in_data_i.center_tile_y != used_y_q) ||
                   (in_data_i.zoom_level != used_zoom_q);

  assign job_valid_o = in_valid_i && changed;

  always_comb begin
    job_o.new_x0    = twdp_pkg::COORD_W'({2'b00, in_data_i.center_tile_x}) -
                      twdp_pkg::COORD_W'(new_side >> 1);
    job_o.new_y0    = twdp_pkg::COORD_W'({2'b00, in_data_i.center_tile_y}) -
                      twdp_pkg::COORD_W'(new_side >> 1);
    job_o.old_x0    = twdp_pkg::COORD_W'({2'b00, used_x_q}) -
                      twdp_pkg::COORD_W'(old_side >> 1);
    job_o.old_y0    = twdp_pkg::COORD_W'({2'b00, used_y_q}) -
                      twdp_pkg::COORD_W'(old_side >> 1);
    // Offsets of each window's origin within the other window.
    job_o.ld_dx     = job_o.new_x0 - job_o.old_x0;
    job_o.ld_dy     = job_o.new_y0 - job_o.old_y0;
    job_o.ds_dx     = job_o.old_x0 - job_o.new_x0;
    job_o.ds_dy     = job_o.old_y0 - job_o.new_y0;
    job_o.new_side  = new_side;
    job_o.old_side  = old_side;
    job_o.new_zoom  = in_data_i.zoom_level;
    job_o.old_zoom  = used_zoom_q;
    job_o.same_zoom = (in_data_i.zoom_level == used_zoom_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cfg_q  <= twdp_pkg::SIDE_RESET;
      used_x_q    <= '0;
      used_y_q    <= '0;
      used_zoom_q <= '0;
      used_side_q <= '0;
      win_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        side_cfg_q <= cfg_data_i;
      end
      if (accept && changed) begin
        used_x_q    <= in_data_i.center_tile_x;
        used_y_q    <= in_data_i.center_tile_y;
        used_zoom_q <= in_data_i.zoom_level;
        used_side_q <= new_side;
        win_valid_q <= 1'b1;
      end
    end
  end

endmodule

[sv/twdp_job_fifo.sv]
// Two-entry job queue between the front and the back.
// Depends on twdp_pkg for the job type.
module twdp_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  twdp_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output twdp_pkg::job_t pop_data_o
);

  localparam int unsigned DEPTH = 2;

  twdp_pkg::job_t mem_q [DEPTH];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;
  logic           push;
  logic           pop;

  assign push_ready_o = (count_q != 2'(DEPTH));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

[sv/twdp_back.sv]
// Back end: walks the new then the old window and emits the tiles that differ.
// Depends on twdp_pkg and the assertion macros in tile_window_diff_pager_defines.svh.
`include "tile_window_diff_pager_defines.svh"

module twdp_back #(
  parameter int unsigned MAX_SIDE = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  twdp_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output twdp_pkg::out_t out_data_o
);

  localparam int unsigned CNT_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  twdp_pkg::phase_e state_q, state_d;
  logic [CNT_W-1:0] i_q;
  logic [CNT_W-1:0] j_q;
  twdp_pkg::out_t   h_q;
  logic             h_valid_q;
  twdp_pkg::out_t   o_q;
  logic             o_valid_q;

  logic                         scan;
  logic                         is_ld;
  logic [twdp_pkg::SIDE_W-1:0]  cur_side;
  logic [twdp_pkg::SIDE_W-1:0]  oth_side;
  logic signed [31:0]           base_x;
  logic signed [31:0]           base_y;
  logic [31:0]                  off_x;
  logic [31:0]                  off_y;
  logic                         in_x;
  logic                         in_y;
  logic                         cand;
  logic                         emit;
  logic                         out_free;
  logic                         stall;
  logic                         last_i;
  logic                         last_j;
  logic                         step;
  logic                         scan_done;
  logic                         flush_go;
  logic                         h_load;
  logic                         o_load;
  twdp_pkg::out_t               h_d;
  twdp_pkg::out_t               o_d;

  always_comb begin
    scan     = (state_q == twdp_pkg::PH_LOAD) || (state_q == twdp_pkg::PH_DISPOSE);
    is_ld    = (state_q == twdp_pkg::PH_LOAD);
    cur_side = is_ld ? job_i.new_side : job_i.old_side;
    oth_side = is_ld ? job_i.old_side : job_i.new_side;
    base_x   = is_ld ? job_i.new_x0 : job_i.old_x0;
    base_y   = is_ld ? job_i.new_y0 : job_i.old_y0;
    // A negative offset wraps to a large unsigned value and falls outside.
    off_x    = (is_ld ? job_i.ld_dx : job_i.ds_dx) + 32'(i_q);
    off_y    = (is_ld ? job_i.ld_dy : job_i.ds_dy) + 32'(j_q);
    in_x     = off_x < 32'(oth_side);
    in_y     = off_y < 32'(oth_side);
    cand     = scan && (cur_side != '0);
    emit     = cand && !(job_i.same_zoom && in_x && in_y);
    out_free = !o_valid_q || out_ready_i;
    stall    = emit && h_valid_q && !out_free;
    last_i   = (twdp_pkg::SIDE_W'(i_q) == cur_side - 3'd1);
    last_j   = (twdp_pkg::SIDE_W'(j_q) == cur_side - 3'd1);
    step     = cand && !stall;
    scan_done = scan && !stall && (!cand || (last_i && last_j));
    flush_go = !h_valid_q || out_free;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      twdp_pkg::PH_IDLE: begin
        if (job_valid_i) begin
          state_d = twdp_pkg::PH_LOAD;
        end
      end
      twdp_pkg::PH_LOAD: begin
        if (scan_done) begin
          state_d = twdp_pkg::PH_DISPOSE;
        end
      end
      twdp_pkg::PH_DISPOSE: begin
        if (scan_done) begin
          state_d = twdp_pkg::PH_FLUSH;
        end
      end
      twdp_pkg::PH_FLUSH: begin
        if (flush_go) begin
          state_d = twdp_pkg::PH_IDLE;
        end
      end
      default: state_d = twdp_pkg::PH_IDLE;
    endcase
  end

  // Output logic. A result waits in the hold stage until the next one or the
  // end of the run shows whether it is the last.
  always_comb begin
    job_pop_o = 1'b0;
    h_load    = 1'b0;
    o_load    = 1'b0;
    case (state_q)
      twdp_pkg::PH_LOAD, twdp_pkg::PH_DISPOSE: begin
        h_load = step && emit;
        o_load = step && emit && h_valid_q;
      end
      twdp_pkg::PH_FLUSH: begin
        job_pop_o = flush_go;
        o_load    = h_valid_q && out_free;
      end
      default: begin
        job_pop_o = 1'b0;
      end
    endcase
    h_d.action      = is_ld ? twdp_pkg::ACT_LOAD : twdp_pkg::ACT_DISPOSE;
    h_d.tile_x      = base_x + 32'(i_q);
    h_d.tile_y      = base_y + 32'(j_q);
    h_d.tile_zoom   = is_ld ? job_i.new_zoom : job_i.old_zoom;
    h_d.last_of_run = 1'b0;
    o_d             = h_q;
    o_d.last_of_run = (state_q == twdp_pkg::PH_FLUSH);
  end

  always_ff @(posedge clk_i) begin
    if (h_load) begin
      h_q <= h_d;
    end
    if (o_load) begin
      o_q <= o_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= twdp_pkg::PH_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      h_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (scan_done || !scan) begin
        i_q <= '0;
        j_q <= '0;
      end else if (step) begin
        if (last_j) begin
          j_q <= '0;
          i_q <= i_q + CNT_W'(1);
        end else begin
          j_q <= j_q + CNT_W'(1);
        end
      end
      if (h_load) begin
        h_valid_q <= 1'b1;
      end else if (job_pop_o) begin
        h_valid_q <= 1'b0;
      end
      if (o_load) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

  `TWDP_ASSERT(a_idle_no_hold, clk_i, rst_ni, (state_q == twdp_pkg::PH_IDLE) |-> !h_valid_q, "held result outside a run")
  `TWDP_ASSERT(a_pop_has_job, clk_i, rst_ni, job_pop_o |-> job_valid_i, "job popped from an empty queue")
  `TWDP_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cand && (twdp_pkg::SIDE_W'(i_q) >= cur_side), "window counter beyond side")
  `TWDP_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, o_load && !out_free, "output register overwritten")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for tile_window_diff_pager: table-driven directed rows,
// then randomized pan and zoom traffic checked against a behavioral window model.
// Depends on twdp_pkg and the tile_window_diff_pager RTL.
module tb_top;

  localparam int MAX_SIDE = 4;
  localparam int HALF_DIV = 2;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [29:0] CMAX = '1;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct {
    bit             is_cfg;
    logic [2:0]     side;
    twdp_pkg::in_t  center;
    int             n_typed;  // -1 means the window model supplies the expectation
    twdp_pkg::out_t t0;
    twdp_pkg::out_t t1;
  } plan_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [2:0]     cfg_data_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  twdp_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  twdp_pkg::out_t out_data_o;

  // Window model state.
  logic [2:0]     side_reg = twdp_pkg::SIDE_RESET;
  logic [29:0]    used_x = '0;
  logic [29:0]    used_y = '0;
  logic [4:0]     used_zoom = '0;
  logic [2:0]     used_side = '0;
  logic           win_valid = 1'b0;
  twdp_pkg::out_t pred_tiles[32];
  int             pred_n;

  twdp_pkg::out_t tiles_due[$];
  twdp_pkg::in_t  last_center = '0;
  plan_row_t      plan[$];
  int             mismatches = 0;
  int             centers_sent = 0;
  int             tiles_seen = 0;
  int             side_writes = 0;
  int             burst_left = 0;
  int             cycles = 0;

  rx_mode_e       rx_mode = RX_OPEN;
  int             rx_left = 0;
  logic [7:0]     rx_pat = 8'hff;

  tile_window_diff_pager uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic bit in_span(longint v, longint lo, longint side);
    return v >= lo && v < lo + side;
  endfunction

  function automatic twdp_pkg::out_t tile(logic act, logic signed [31:0] x,
                                          logic signed [31:0] y, logic [4:0] z,
                                          logic last);
    twdp_pkg::out_t t;
    t.action = act;
    t.tile_x = x;
    t.tile_y = y;
    t.tile_zoom = z;
    t.last_of_run = last;
    return t;
  endfunction

  function automatic void due_tile(twdp_pkg::out_t t);
    tiles_due.insert(tiles_due.size(), t);
  endfunction

  function automatic void plan_add(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_tile(logic act, longint x, longint y, logic [4:0] z);
    pred_tiles[pred_n] = tile(act, x[31:0], y[31:0], z, 1'b0);
    pred_n++;
  endfunction

  // Computes the load list and then the dispose list for one new center.
  function automatic void page_window(input twdp_pkg::in_t c);
    longint nside, oside, nx0, ny0, ox0, oy0, x, y;
    int i, j;
    logic same_zoom;
    pred_n = 0;
    if (win_valid && c.center_tile_x == used_x && c.center_tile_y == used_y &&
        c.zoom_level == used_zoom)
      return;
    nside = (longint'(side_reg) > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(side_reg);
    oside = win_valid ? longint'(used_side) : longint'(0);
    nx0 = longint'(c.center_tile_x) - nside / HALF_DIV;
    ny0 = longint'(c.center_tile_y) - nside / HALF_DIV;
    ox0 = longint'(used_x) - oside / HALF_DIV;
    oy0 = longint'(used_y) - oside / HALF_DIV;
    same_zoom = (c.zoom_level == used_zoom);
    for (i = 0; i < nside; i++) begin
      for (j = 0; j < nside; j++) begin
        x = nx0 + i;
        y = ny0 + j;
        if (!(same_zoom && in_span(x, ox0, oside) && in_span(y, oy0, oside)))
          add_tile(twdp_pkg::ACT_LOAD, x, y, c.zoom_level);
      end
    end
    for (i = 0; i < oside; i++) begin
      for (j = 0; j < oside; j++) begin
        x = ox0 + i;
        y = oy0 + j;
        if (!(same_zoom && in_span(x, nx0, nside) && in_span(y, ny0, nside)))
          add_tile(twdp_pkg::ACT_DISPOSE, x, y, used_zoom);
      end
    end
    if (pred_n > 0)
      pred_tiles[pred_n-1].last_of_run = 1'b1;
    used_x = c.center_tile_x;
    used_y = c.center_tile_y;
    used_zoom = c.zoom_level;
    used_side = nside[2:0];
    win_valid = 1'b1;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    twdp_pkg::out_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      tiles_seen++;
      if (tiles_due.size() == 0) begin
        $error("unexpected tile transfer: x %0d y %0d",
               out_data_o.tile_x, out_data_o.tile_y);
        mismatches++;
      end else begin
        w = tiles_due.pop_front();
        check_field("action", longint'(w.action), longint'(out_data_o.action));
        check_field("tile_x", longint'(w.tile_x), longint'(out_data_o.tile_x));
        check_field("tile_y", longint'(w.tile_y), longint'(out_data_o.tile_y));
        check_field("tile_zoom", longint'(w.tile_zoom), longint'(out_data_o.tile_zoom));
        check_field("last_of_run", longint'(w.last_of_run),
                    longint'(out_data_o.last_of_run));
      end
    end
  end

  // The receiver switches between always-ready, random stalls and a repeating pattern.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 80);
      rx_pat <= 8'($urandom) | 8'h01;
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    out_ready_i <= 1'b1;
      RX_RANDOM:  out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: out_ready_i <= rx_pat[rx_left % 8];
      default:    out_ready_i <= 1'b1;
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so back-to-back centers keep valid asserted.
  task automatic send_center(input twdp_pkg::in_t c, input int n_typed,
                             input twdp_pkg::out_t t0, input twdp_pkg::out_t t1);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      if ($urandom_range(0, 3) != 0)
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i = c;
    last_center = c;
    do @(posedge clk_i); while (!in_ready_o);
    centers_sent++;
    page_window(c);
    if (n_typed < 0) begin
      for (int k = 0; k < pred_n; k++)
        due_tile(pred_tiles[k]);
    end else begin
      if (n_typed > 0)
        due_tile(t0);
      if (n_typed > 1)
        due_tile(t1);
    end
    @(negedge clk_i);
  endtask

  // Lets the block drain; centers that page nothing may still be in its queue.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (tiles_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_side(input logic [2:0] v);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    side_reg = v;
    side_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic plan_row_t side_row(logic [2:0] v);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.side = v;
    return r;
  endfunction

  function automatic plan_row_t center_row(logic [29:0] x, logic [29:0] y, logic [4:0] z,
                                           int n_typed = -1,
                                           twdp_pkg::out_t t0 = '0,
                                           twdp_pkg::out_t t1 = '0);
    plan_row_t r;
    r = '{default: '0};
    r.center.center_tile_x = x;
    r.center.center_tile_y = y;
    r.center.zoom_level = z;
    r.n_typed = n_typed;
    r.t0 = t0;
    r.t1 = t1;
    return r;
  endfunction

  // Mostly small pans at a fixed zoom so windows overlap; the rest repeats,
  // zoom changes, far jumps and centers at the edges of the coordinate range.
  function automatic twdp_pkg::in_t random_center();
    twdp_pkg::in_t c;
    int pick;
    c = last_center;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      c.center_tile_x = c.center_tile_x + 30'($urandom_range(0, 4) - 2);
      c.center_tile_y = c.center_tile_y + 30'($urandom_range(0, 4) - 2);
    end else if (pick < 70) begin
      c = last_center;
    end else if (pick < 80) begin
      c.zoom_level = 5'($urandom_range(0, 31));
    end else if (pick < 90) begin
      c.center_tile_x = 30'($urandom);
      c.center_tile_y = 30'($urandom);
      c.zoom_level = 5'($urandom);
    end else begin
      c.center_tile_x = $urandom_range(0, 1) ? 30'($urandom_range(0, 2)) :
                                               CMAX - 30'($urandom_range(0, 2));
      c.center_tile_y = $urandom_range(0, 1) ? 30'($urandom_range(0, 2)) :
                                               CMAX - 30'($urandom_range(0, 2));
    end
    return c;
  endfunction

  initial begin
    logic [2:0] phase_side[8];
    twdp_pkg::in_t c;
    phase_side = '{3'd2, 3'd4, 3'd1, 3'd0, 3'd3, 3'd7, 3'd5, 3'd6};

    // First center after reset pages a full 3x3 window.
    plan_add(center_row(30'd5, 30'd7, 5'd3));
    plan_add(center_row(30'd5, 30'd7, 5'd3, 0));
    plan_add(side_row(3'd1));
    // A side change alone pages nothing.
    plan_add(center_row(30'd5, 30'd7, 5'd3, 0));
    plan_add(center_row(30'd6, 30'd7, 5'd3));
    plan_add(center_row(CMAX, CMAX, 5'd31, 2,
                        tile(twdp_pkg::ACT_LOAD, {2'b00, CMAX}, {2'b00, CMAX}, 5'd31, 1'b0),
                        tile(twdp_pkg::ACT_DISPOSE, 32'sd6, 32'sd7, 5'd3, 1'b1)));
    plan_add(center_row(30'd0, 30'd0, 5'd0, 2,
                        tile(twdp_pkg::ACT_LOAD, 32'sd0, 32'sd0, 5'd0, 1'b0),
                        tile(twdp_pkg::ACT_DISPOSE, {2'b00, CMAX}, {2'b00, CMAX}, 5'd31,
                             1'b1)));
    plan_add(side_row(3'd4));
    plan_add(center_row(30'd0, 30'd0, 5'd0, 0));
    // Windows near the origin reach negative tile coordinates.
    plan_add(center_row(30'd0, 30'd0, 5'd1));
    plan_add(center_row(30'd1, 30'd0, 5'd1));
    plan_add(center_row(30'd1, 30'd1, 5'd1));
    plan_add(center_row(CMAX, 30'd0, 5'd1));
    plan_add(side_row(3'd0));
    plan_add(center_row(CMAX, 30'd0, 5'd1, 0));
    // An empty window only disposes the old one.
    plan_add(center_row(30'd3, 30'd3, 5'd2));
    plan_add(center_row(30'd4, 30'd4, 5'd2, 0));
    plan_add(side_row(3'd7));
    plan_add(center_row(30'd4, 30'd4, 5'd2, 0));
    plan_add(center_row(30'd4, 30'd5, 5'd2));
    plan_add(side_row(3'd5));
    plan_add(center_row(30'd4, 30'd6, 5'd2));
    plan_add(side_row(3'd2));
    plan_add(center_row(30'd4, 30'd6, 5'd2, 0));
    plan_add(center_row(30'd4, 30'd7, 5'd2));
    plan_add(center_row(30'd4, 30'd7, 5'd31));
    plan_add(side_row(3'd3));
    plan_add(center_row(30'h2000_0000, 30'h1fff_ffff, 5'd16));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_cfg)
        write_side(plan[k].side);
      else
        send_center(plan[k].center, plan[k].n_typed, plan[k].t0, plan[k].t1);
    end

    foreach (phase_side[p]) begin
      write_side(phase_side[p]);
      repeat ((phase_side[p] == 3'd0) ? 10 : 42) begin
        c = random_center();
        send_center(c, -1, '0, '0);
      end
    end

    wait_idle();
    $display("tb_top: %0d centers sent, %0d tiles checked, %0d side writes",
             centers_sent, tiles_seen, side_writes);
    $display("tb_top: sides 0 to 7 used, with overlapping pans, zoom changes and edge centers");
    if (mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

[tile_window_diff_pager.f]
+incdir+sv
sv/twdp_pkg.sv
sv/twdp_front.sv
sv/twdp_job_fifo.sv
sv/twdp_back.sv
sv/tile_window_diff_pager.sv
sim/tb_top.sv
